### rtl/bdd_pkg.sv
// ----------------------------------------------------------------------------
// bdd_pkg
// Shared constants and types for the binary to decimal digit converter.
// ----------------------------------------------------------------------------
package bdd_pkg;

  // Sizing of the converter
  localparam int MAX_DIGITS = 20;
  localparam int VALUE_BITS = 64;
  localparam int NUMBER_W   = 64;
  localparam int DIGIT_W    = 6;
  localparam int BCD_W      = 4 * MAX_DIGITS;
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);
  localparam int REM_W      = $clog2(MAX_DIGITS + 1);

  // Character and digit codes
  localparam logic [DIGIT_W-1:0] ASCII_ZERO = 6'd48;
  localparam logic [3:0]         DIGIT_NINE = 4'd9;
  localparam logic [3:0]         DIGIT_FIVE = 4'd5;
  localparam logic [3:0]         DIGIT_ADJ  = 4'd3;

  // Digit serializer states
  typedef enum logic [1:0] {
    EMIT_IDLE,
    EMIT_SKIP,
    EMIT_SEND
  } emit_state_t;

  // Status of the shift-and-add-3 converter
  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } dab_stat_t;

endpackage

### rtl/bdd_dabble.sv
// ----------------------------------------------------------------------------
// bdd_dabble
// Bit-serial shift-and-add-3 converter: one binary bit enters the BCD
// register per cycle, with a sticky flag for values that overflow it.
// ----------------------------------------------------------------------------
module bdd_dabble (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [bdd_pkg::VALUE_BITS-1:0] value,
  output bdd_pkg::dab_stat_t           stat,
  output logic [bdd_pkg::BCD_W-1:0]    bcd
);
  import bdd_pkg::*;

  logic [VALUE_BITS-1:0] bin;
  logic [BCD_W-1:0]      bcd_reg;
  logic [BCD_W-1:0]      adj;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  logic                  done;
  logic                  ovf;

  // Add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd_reg[4*i +: 4] >= DIGIT_FIVE) begin
        adj[4*i +: 4] = bcd_reg[4*i +: 4] + DIGIT_ADJ;
      end else begin
        adj[4*i +: 4] = bcd_reg[4*i +: 4];
      end
    end
  end

  // Busy while bits remain to shift in; pulse done after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Shift the binary value into the adjusted BCD register
  always_ff @(posedge clk) begin
    if (start) begin
      bin     <= value;
      bcd_reg <= '0;
      ovf     <= 1'b0;
      cnt     <= CNT_W'(VALUE_BITS);
    end else if (busy) begin
      bcd_reg <= {adj[BCD_W-2:0], bin[VALUE_BITS-1]};
      bin     <= {bin[VALUE_BITS-2:0], 1'b0};
      ovf     <= ovf | adj[BCD_W-1];
      cnt     <= cnt - CNT_W'(1);
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign stat.ovf  = ovf;
  assign bcd       = bcd_reg;

endmodule

### rtl/bdd_emit.sv
// ----------------------------------------------------------------------------
// bdd_emit
// Digit serializer: drops leading zeros, then sends one ASCII digit per
// transfer through an output register, most significant first.
// ----------------------------------------------------------------------------
module bdd_emit (
  input  logic                           clk,
  input  logic                           rst,
  input  bdd_pkg::dab_stat_t             stat,
  input  logic [bdd_pkg::BCD_W-1:0]      bcd,
  output logic                           busy,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bdd_pkg::DIGIT_W-1:0]    digit_code,
  output logic                           last_digit
);
  import bdd_pkg::*;

  emit_state_t      state;
  emit_state_t      state_next;
  logic [BCD_W-1:0] shreg;
  logic [REM_W-1:0] rem;
  logic [3:0]       top;
  logic             load_out;
  logic             shift;

  assign top = shreg[BCD_W-1 -: 4];

  // Next state and shift control
  always_comb begin
    state_next = state;
    shift      = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      EMIT_IDLE: begin
        if (stat.done) state_next = EMIT_SKIP;
      end
      EMIT_SKIP: begin
        if (top == 4'd0 && rem > REM_W'(1)) begin
          shift = 1'b1;
        end else begin
          state_next = EMIT_SEND;
        end
      end
      EMIT_SEND: begin
        if (!out_valid || out_ready) begin
          load_out = 1'b1;
          shift    = 1'b1;
          if (rem == REM_W'(1)) state_next = EMIT_IDLE;
        end
      end
      default: state_next = EMIT_IDLE;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= EMIT_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load digits, saturate to nines on overflow, advance a digit per shift
  always_ff @(posedge clk) begin
    if (stat.done) begin
      shreg <= stat.ovf ? {MAX_DIGITS{DIGIT_NINE}} : bcd;
      rem   <= REM_W'(MAX_DIGITS);
    end else if (shift) begin
      shreg <= {shreg[BCD_W-5:0], 4'd0};
      rem   <= rem - REM_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      digit_code <= ASCII_ZERO + {2'b00, top};
      last_digit <= (rem == REM_W'(1));
    end
  end

  assign busy = (state != EMIT_IDLE);

endmodule

### rtl/binary_to_decimal_digits_top.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_digits_top
// Converts an unsigned binary value into ASCII decimal digits.
// ----------------------------------------------------------------------------
// One value is taken per transfer on the input channel and comes out as
// its decimal digits in ASCII, most significant first, without leading
// zeros; zero gives a single '0'. The last digit of each value has
// last_digit set. The conversion shifts one binary bit per cycle through
// a shift-and-add-3 BCD register, then hands the digits over to the
// serializer, which drops the leading zeros and sends the rest; a digit
// that waits on out_ready holds back the digits behind it. A new value
// is accepted once the last digit of the previous one sits in the output
// register.
module binary_to_decimal_digits_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bdd_pkg::NUMBER_W-1:0]   number,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bdd_pkg::DIGIT_W-1:0]    digit_code,
  output logic                           last_digit
);
  import bdd_pkg::*;

  dab_stat_t        dstat;
  logic [BCD_W-1:0] bcd;
  logic             emit_busy;
  logic             start;

  // Accept a value only when both stages are free
  assign in_ready = !dstat.busy && !dstat.done && !emit_busy;
  assign start    = in_valid && in_ready;

  bdd_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .value (number[VALUE_BITS-1:0]),
    .stat  (dstat),
    .bcd   (bcd)
  );

  bdd_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .stat       (dstat),
    .bcd        (bcd),
    .busy       (emit_busy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .digit_code (digit_code),
    .last_digit (last_digit)
  );

endmodule

### rtl/bdd_checker.sv
// ----------------------------------------------------------------------------
// bdd_checker
// Port-level checks for the binary to decimal digit converter.
// ----------------------------------------------------------------------------
module bdd_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bdd_pkg::DIGIT_W-1:0]  digit_code,
  input logic                         last_digit
);
  import bdd_pkg::*;

  // Hold a stalled digit
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digit_code) && $stable(last_digit))
    else $error("stalled digit changed");

  // Send only decimal digit characters
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> digit_code >= ASCII_ZERO && digit_code <= ASCII_ZERO + 6'd9)
    else $error("digit code out of range");

  // Drop ready right after a value transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready after accepted value");

  // Take no value while a run is still being sent
  a_no_accept_mid_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_digit |-> !in_ready)
    else $error("value accepted mid run");

endmodule

bind binary_to_decimal_digits_top bdd_checker u_bdd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .digit_code (digit_code),
  .last_digit (last_digit)
);
